// File: rtl/resp_reply_stream_parser_top_assert.svh
// assertion macros shared by the resp reply parser rtl
`ifndef RESP_REPLY_STREAM_PARSER_TOP_ASSERT_SVH
`define RESP_REPLY_STREAM_PARSER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define RRSP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RRSP_ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RRSP_ASSERT(label, clk, rst_n, prop, msg)
`define RRSP_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// File: rtl/rrsp_pkg.sv
// types and constants of the resp reply stream parser
`timescale 1ns / 1ps
`default_nettype none
package rrsp_pkg;

  typedef enum logic [2:0] {
    PH_PREFIX,
    PH_LINE,
    PH_LINE_LF,
    PH_NUM,
    PH_NUM_LF,
    PH_DATA,
    PH_DATA_CR,
    PH_DATA_LF
  } phase_t;

  typedef enum logic [3:0] {
    K_SIMPLE     = 4'd0,
    K_ERROR      = 4'd1,
    K_INTEGER    = 4'd2,
    K_BULK       = 4'd3,
    K_NULL       = 4'd4,
    K_EMPTY      = 4'd5,
    K_UNKNOWN    = 4'd6,
    K_INCOMPLETE = 4'd7,
    K_MALFORMED  = 4'd8,
    K_OVERFLOW   = 4'd9
  } kind_t;

  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       conn_closed;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic [3:0] elem_kind;
    logic       elem_last;
    logic       reply_last;
    logic [3:0] nest_level;
  } out_word_t;

  typedef struct packed {
    logic push;
    logic finish;
    logic clear;
  } stk_cmd_t;

endpackage
`default_nettype wire

// File: rtl/rrsp_in_if.sv
// input byte channel of the resp reply parser
`timescale 1ns / 1ps
`default_nettype none
interface rrsp_in_if import rrsp_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/rrsp_out_if.sv
// result channel of the resp reply parser
`timescale 1ns / 1ps
`default_nettype none
interface rrsp_out_if import rrsp_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/rrsp_count_stack.sv
// array element count stack whose multi level pop is done by a single finish command
`timescale 1ns / 1ps
`default_nettype none
`include "resp_reply_stream_parser_top_assert.svh"
module rrsp_count_stack import rrsp_pkg::*; #(
  parameter int MAX_DEPTH  = 8,
  parameter int COUNT_BITS = 31,
  localparam int LW = $clog2(MAX_DEPTH + 1),
  localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire stk_cmd_t              cmd,
  input  wire logic [COUNT_BITS-1:0] push_val,
  output logic      [LW-1:0]         level,
  output logic                       reply_done
);

  logic [COUNT_BITS-1:0] cnt_r [MAX_DEPTH];
  logic [MAX_DEPTH-1:0]  one_r;
  logic [LW-1:0]         level_r;
  logic [LW-1:0]         level_nxt;
  logic                  hit;
  logic [IW-1:0]         k;
  logic [COUNT_BITS-1:0] rd_val;
  logic                  wr_en;
  logic [IW-1:0]         wr_idx;
  logic [COUNT_BITS-1:0] wr_val;
  logic                  wr_one;

  // innermost open array whose count does not run out on this element
  always_comb begin
    hit = 1'b0;
    k   = '0;
    for (int i = 0; i < MAX_DEPTH; i++) begin
      if ((LW'(i) < level_r) && !one_r[i]) begin
        hit = 1'b1;
        k   = IW'(i);
      end
    end
  end

  assign rd_val     = cnt_r[k];
  assign reply_done = !hit;
  assign level      = level_r;

  always_comb begin
    level_nxt = level_r;
    wr_en     = 1'b0;
    wr_idx    = level_r[IW-1:0];
    wr_val    = push_val;
    wr_one    = (push_val == COUNT_BITS'(1));
    priority if (cmd.clear) begin
      level_nxt = '0;
    end else if (cmd.push) begin
      wr_en     = 1'b1;
      level_nxt = level_r + 1'b1;
    end else if (cmd.finish) begin
      if (hit) begin
        wr_en     = 1'b1;
        wr_idx    = k;
        wr_val    = rd_val - 1'b1;
        wr_one    = (rd_val == COUNT_BITS'(2));
        level_nxt = LW'(k) + LW'(1);
      end else begin
        level_nxt = '0;
      end
    end else begin
      level_nxt = level_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
    end else begin
      level_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cnt_r[wr_idx] <= wr_val;
      one_r[wr_idx] <= wr_one;
    end
  end

  `RRSP_ASSERT(a_level_bound, clk, rst_n, level_r <= LW'(MAX_DEPTH), "stack level past depth")
  `RRSP_ASSERT(a_cmd_excl, clk, rst_n, $onehot0({cmd.push, cmd.finish, cmd.clear}), "stack cmd clash")
  `RRSP_ASSERT(a_clear_empty, clk, rst_n, cmd.clear |=> level_r == '0, "clear left arrays open")
  `RRSP_ASSERT(a_push_grow, clk, rst_n, cmd.push |=> level_r == $past(level_r) + 1'b1, "push lost")

endmodule
`default_nettype wire

// File: rtl/rrsp_core.sv
// per byte parse state machine: prefix, line, length and bulk phases
`timescale 1ns / 1ps
`default_nettype none
module rrsp_core import rrsp_pkg::*; #(
  parameter int MAX_DEPTH  = 8,
  parameter int COUNT_BITS = 31,
  localparam int LW = $clog2(MAX_DEPTH + 1),
  localparam int NW = COUNT_BITS + 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  step,
  input  wire in_word_t              in_word,
  input  wire logic [LW-1:0]         level,
  input  wire logic                  reply_done,
  output logic                       res_valid,
  output out_word_t                  res,
  output stk_cmd_t                   cmd,
  output logic      [COUNT_BITS-1:0] push_val
);

  phase_t                phase_r, phase_nxt;
  kind_t                 kind_r, kind_nxt;
  logic [COUNT_BITS-1:0] accum_r, accum_nxt;
  logic                  neg_r, neg_nxt;
  logic                  digits_r, digits_nxt;
  logic                  bad_r, bad_nxt;
  logic [COUNT_BITS-1:0] bulk_r, bulk_nxt;
  logic [7:0]            b;
  logic [NW-1:0]         nv;
  logic                  is_digit;
  logic                  do_finish;
  logic                  do_abandon;
  kind_t                 end_kind;
  logic [3:0]            nest;

  assign b        = in_word.data_byte;
  assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
  assign nv       = (NW'(accum_r) << 3) + (NW'(accum_r) << 1) + NW'(b - CH_ZERO);
  assign nest     = 4'(level);
  assign push_val = accum_r;

  always_comb begin
    phase_nxt  = phase_r;
    kind_nxt   = kind_r;
    accum_nxt  = accum_r;
    neg_nxt    = neg_r;
    digits_nxt = digits_r;
    bad_nxt    = bad_r;
    bulk_nxt   = bulk_r;
    do_finish  = 1'b0;
    do_abandon = 1'b0;
    end_kind   = kind_r;
    res_valid  = 1'b0;
    res        = '0;
    cmd        = '0;
    if (step) begin
      if (in_word.conn_closed) begin
        do_abandon = 1'b1;
        end_kind   = K_INCOMPLETE;
      end else begin
        unique case (phase_r)
          PH_PREFIX: begin
            unique case (b)
              CH_PLUS: begin
                kind_nxt  = K_SIMPLE;
                phase_nxt = PH_LINE;
              end
              CH_MINUS: begin
                kind_nxt  = K_ERROR;
                phase_nxt = PH_LINE;
              end
              CH_COLON: begin
                kind_nxt  = K_INTEGER;
                phase_nxt = PH_LINE;
              end
              CH_DOLLAR, CH_STAR: begin
                kind_nxt   = (b == CH_DOLLAR) ? K_BULK : K_EMPTY;
                accum_nxt  = '0;
                neg_nxt    = 1'b0;
                digits_nxt = 1'b0;
                bad_nxt    = 1'b0;
                phase_nxt  = PH_NUM;
              end
              default: begin
                do_finish = 1'b1;
                end_kind  = K_UNKNOWN;
              end
            endcase
          end
          PH_LINE: begin
            if (b == CH_CR) begin
              phase_nxt = PH_LINE_LF;
            end else begin
              res_valid      = 1'b1;
              res.out_byte   = b;
              res.has_byte   = 1'b1;
              res.elem_kind  = kind_r;
              res.nest_level = nest;
            end
          end
          PH_LINE_LF: begin
            do_finish = 1'b1;
          end
          PH_NUM: begin
            priority if (b == CH_CR) begin
              phase_nxt = PH_NUM_LF;
            end else if (bad_r) begin
              // malformed until the line ends
            end else if (b == CH_MINUS && !digits_r && !neg_r) begin
              neg_nxt = 1'b1;
            end else if (is_digit) begin
              digits_nxt = 1'b1;
              if (nv[NW-1:COUNT_BITS] != '0) begin
                bad_nxt = 1'b1;
              end else begin
                accum_nxt = nv[COUNT_BITS-1:0];
              end
            end else begin
              bad_nxt = 1'b1;
            end
          end
          PH_NUM_LF: begin
            priority if (bad_r || !digits_r) begin
              do_abandon = 1'b1;
              end_kind   = K_MALFORMED;
            end else if (neg_r && accum_r != '0) begin
              if (accum_r == COUNT_BITS'(1)) begin
                do_finish = 1'b1;
                end_kind  = K_NULL;
              end else begin
                do_abandon = 1'b1;
                end_kind   = K_MALFORMED;
              end
            end else if (kind_r == K_BULK) begin
              bulk_nxt  = accum_r;
              phase_nxt = (accum_r == '0) ? PH_DATA_CR : PH_DATA;
            end else if (accum_r == '0) begin
              do_finish = 1'b1;
              end_kind  = K_EMPTY;
            end else if (level == LW'(MAX_DEPTH)) begin
              do_abandon = 1'b1;
              end_kind   = K_OVERFLOW;
            end else begin
              cmd.push  = 1'b1;
              phase_nxt = PH_PREFIX;
            end
          end
          PH_DATA: begin
            bulk_nxt = bulk_r - 1'b1;
            if (bulk_nxt == '0) begin
              phase_nxt = PH_DATA_CR;
            end
            res_valid      = 1'b1;
            res.out_byte   = b;
            res.has_byte   = 1'b1;
            res.elem_kind  = K_BULK;
            res.nest_level = nest;
          end
          PH_DATA_CR: begin
            phase_nxt = PH_DATA_LF;
          end
          PH_DATA_LF: begin
            do_finish = 1'b1;
            end_kind  = K_BULK;
          end
        endcase
      end

      if (do_finish) begin
        cmd.finish     = 1'b1;
        phase_nxt      = PH_PREFIX;
        res_valid      = 1'b1;
        res.elem_kind  = end_kind;
        res.elem_last  = 1'b1;
        res.reply_last = reply_done;
        res.nest_level = nest;
      end
      if (do_abandon) begin
        cmd.clear      = 1'b1;
        phase_nxt      = PH_PREFIX;
        kind_nxt       = K_SIMPLE;
        accum_nxt      = '0;
        neg_nxt        = 1'b0;
        digits_nxt     = 1'b0;
        bad_nxt        = 1'b0;
        bulk_nxt       = '0;
        res_valid      = 1'b1;
        res.elem_kind  = end_kind;
        res.elem_last  = 1'b1;
        res.reply_last = 1'b1;
        res.nest_level = nest;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_PREFIX;
      kind_r   <= K_SIMPLE;
      accum_r  <= '0;
      neg_r    <= 1'b0;
      digits_r <= 1'b0;
      bad_r    <= 1'b0;
      bulk_r   <= '0;
    end else begin
      phase_r  <= phase_nxt;
      kind_r   <= kind_nxt;
      accum_r  <= accum_nxt;
      neg_r    <= neg_nxt;
      digits_r <= digits_nxt;
      bad_r    <= bad_nxt;
      bulk_r   <= bulk_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/resp_reply_stream_parser_top.sv
// top level of the resp reply stream parser
//
//  channel | dir | payload                                         | handshake
//  in_ch   | in  | data_byte, conn_closed                          | valid/ready
//  out_ch  | out | out_byte, has_byte, elem_kind, elem_last,       | valid/ready
//          |     | reply_last, nest_level                          |
//
// one byte per cycle sustained while out_ch is ready; a taken byte passes the input register, then the result register
// every byte is parsed combinationally between the input register and the result register
// element end pops all finished arrays in the same cycle it is parsed through the count stack
// synchronous reset clears the parse state and the open array count; stack entries need none
// a stalled result holds; one more byte waits in the input register before ready drops
`timescale 1ns / 1ps
`default_nettype none
`include "resp_reply_stream_parser_top_assert.svh"
module resp_reply_stream_parser_top import rrsp_pkg::*; #(
  parameter int MAX_DEPTH  = 8,
  parameter int COUNT_BITS = 31
) (
  input wire logic    clk,
  input wire logic    rst_n,
  rrsp_in_if.sink     in_ch,
  rrsp_out_if.source  out_ch
);

  localparam int LW = $clog2(MAX_DEPTH + 1);

  logic                  in_v_r, in_v_nxt;
  in_word_t              in_word_r;
  logic                  out_v_r, out_v_nxt;
  out_word_t             out_word_r;
  logic                  adv;
  logic                  res_valid;
  out_word_t             res;
  stk_cmd_t              cmd;
  logic [COUNT_BITS-1:0] push_val;
  logic [LW-1:0]         level;
  logic                  reply_done;

  // a word is parsed when the result register is free or drains now
  assign adv          = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready  = !in_v_r || adv;
  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_word_r;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_ch.ready) begin
      in_v_nxt = in_ch.valid;
    end
    out_v_nxt = out_v_r;
    if (adv && res_valid) begin
      out_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_word_r <= in_ch.data;
    end
    if (adv && res_valid) begin
      out_word_r <= res;
    end
  end

  rrsp_core #(
    .MAX_DEPTH  (MAX_DEPTH),
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (adv),
    .in_word    (in_word_r),
    .level      (level),
    .reply_done (reply_done),
    .res_valid  (res_valid),
    .res        (res),
    .cmd        (cmd),
    .push_val   (push_val)
  );

  rrsp_count_stack #(
    .MAX_DEPTH  (MAX_DEPTH),
    .COUNT_BITS (COUNT_BITS)
  ) u_stack (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .push_val   (push_val),
    .level      (level),
    .reply_done (reply_done)
  );

  `RRSP_ASSERT_NORST(a_rst_out, clk, !rst_n |=> !out_v_r, "result valid after reset")
  `RRSP_ASSERT(a_byte_word, clk, rst_n, out_v_r && out_word_r.has_byte |-> !out_word_r.elem_last && !out_word_r.reply_last, "payload word marked as end")
  `RRSP_ASSERT(a_marker_word, clk, rst_n, out_v_r && !out_word_r.has_byte |-> out_word_r.elem_last && out_word_r.out_byte == 8'h00, "marker word malformed")

endmodule
`default_nettype wire
